@@ design/dgpcd_pkg.sv @@
// ----------------------------------------------------------------------------
// dgpcd_pkg
// Shared constants for the dew-guarded PI cooler drive: register map, reset
// values and the default integral precision.
// ----------------------------------------------------------------------------
package dgpcd_pkg;

  localparam int INTEGRAL_FRAC_BITS = 16;

  localparam int TEMP_W  = 16;
  localparam int GAIN_W  = 16;
  localparam int DUTY_W  = 14;
  localparam int CFG_AW  = 5;
  localparam int CFG_DW  = 32;
  localparam int REG_IW  = 3;

  localparam logic [DUTY_W-1:0] DUTY_CAP = DUTY_W'(10000);

  // register indexes (byte address = 4 * index)
  localparam logic [REG_IW-1:0] REG_TARGET_TEMP   = 3'd0;
  localparam logic [REG_IW-1:0] REG_PROP_GAIN     = 3'd1;
  localparam logic [REG_IW-1:0] REG_INTEG_GAIN    = 3'd2;
  localparam logic [REG_IW-1:0] REG_DUTY_MIN      = 3'd3;
  localparam logic [REG_IW-1:0] REG_DUTY_MAX      = 3'd4;
  localparam logic [REG_IW-1:0] REG_ENTER_MARGIN  = 3'd5;
  localparam logic [REG_IW-1:0] REG_EXIT_MARGIN   = 3'd6;

  localparam logic signed [TEMP_W-1:0] RST_TARGET_TEMP  = 16'sd6400;
  localparam logic [GAIN_W-1:0]        RST_PROP_GAIN    = 16'd1000;
  localparam logic [GAIN_W-1:0]        RST_INTEG_GAIN   = 16'd256;
  localparam logic [DUTY_W-1:0]        RST_DUTY_MIN     = 14'd0;
  localparam logic [DUTY_W-1:0]        RST_DUTY_MAX     = 14'd10000;
  localparam logic signed [TEMP_W-1:0] RST_ENTER_MARGIN = 16'sd384;
  localparam logic signed [TEMP_W-1:0] RST_EXIT_MARGIN  = 16'sd1024;

endpackage

@@ design/dew_guarded_pi_cooler_drive.sv @@
// Data path: an input transfer is captured in the input register, then passes
// through PI and clamp logic into the output register, which drives out_tvalid.
// Throughput: one item per cycle while out_tready is not held low; the integral
// accumulator closes its loop within the PI stage, and the output register decouples a stalled consumer.
// Reset (rst_n low, synchronous): pipeline empty, protection off, integral
// zero, all configuration registers at their documented reset values.
// ----------------------------------------------------------------------------
// dew_guarded_pi_cooler_drive
// PI cooler drive with anti-windup and dew-point hysteresis protection,
// configured over an APB-style port, streaming input and output.
// ----------------------------------------------------------------------------
module dew_guarded_pi_cooler_drive #(
  parameter int INTEGRAL_FRAC_BITS = dgpcd_pkg::INTEGRAL_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata: [15:0] surface_temp, [31:16] dew_point_temp
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,
  // out_tdata: [13:0] duty_per_myriad, [15:14] zero
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [15:0]                   out_tdata,
  // out_tuser: [0] protect_active
  output logic                          out_tuser,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [dgpcd_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [dgpcd_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [dgpcd_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                          cfg_pready
);

  localparam int F   = INTEGRAL_FRAC_BITS;
  localparam int TW  = dgpcd_pkg::TEMP_W;
  localparam int DW  = dgpcd_pkg::DUTY_W;
  localparam int EW  = TW + 1;          // Q9.8 difference
  localparam int MW  = 2 * EW;          // gain x error product
  localparam int PW  = F + 26;          // proportional term
  localparam int IW  = F + 18;          // integral step
  localparam int AW  = F + DW;          // integral accumulator
  localparam int SW  = F + 19;          // accumulator + step
  localparam int OW  = F + 27;          // p + integral

  // ---------------- configuration registers ----------------
  logic signed [TW-1:0] target_temp_r, enter_margin_r, exit_margin_r;
  logic [dgpcd_pkg::GAIN_W-1:0] prop_gain_r, integ_gain_r;
  logic [DW-1:0] duty_min_r, duty_max_r;
  logic [dgpcd_pkg::REG_IW-1:0] cfg_idx;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[dgpcd_pkg::CFG_AW-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_temp_r  <= dgpcd_pkg::RST_TARGET_TEMP;
      prop_gain_r    <= dgpcd_pkg::RST_PROP_GAIN;
      integ_gain_r   <= dgpcd_pkg::RST_INTEG_GAIN;
      duty_min_r     <= dgpcd_pkg::RST_DUTY_MIN;
      duty_max_r     <= dgpcd_pkg::RST_DUTY_MAX;
      enter_margin_r <= dgpcd_pkg::RST_ENTER_MARGIN;
      exit_margin_r  <= dgpcd_pkg::RST_EXIT_MARGIN;
    end else if (cfg_wr) begin
      case (cfg_idx)
        dgpcd_pkg::REG_TARGET_TEMP:  target_temp_r  <= $signed(cfg_pwdata[TW-1:0]);
        dgpcd_pkg::REG_PROP_GAIN:    prop_gain_r    <= cfg_pwdata[15:0];
        dgpcd_pkg::REG_INTEG_GAIN:   integ_gain_r   <= cfg_pwdata[15:0];
        dgpcd_pkg::REG_DUTY_MIN:     duty_min_r     <= cfg_pwdata[DW-1:0];
        dgpcd_pkg::REG_DUTY_MAX:     duty_max_r     <= cfg_pwdata[DW-1:0];
        dgpcd_pkg::REG_ENTER_MARGIN: enter_margin_r <= $signed(cfg_pwdata[TW-1:0]);
        dgpcd_pkg::REG_EXIT_MARGIN:  exit_margin_r  <= $signed(cfg_pwdata[TW-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    case (cfg_idx)
      dgpcd_pkg::REG_TARGET_TEMP:  cfg_prdata = 32'(unsigned'(target_temp_r));
      dgpcd_pkg::REG_PROP_GAIN:    cfg_prdata = 32'(prop_gain_r);
      dgpcd_pkg::REG_INTEG_GAIN:   cfg_prdata = 32'(integ_gain_r);
      dgpcd_pkg::REG_DUTY_MIN:     cfg_prdata = 32'(duty_min_r);
      dgpcd_pkg::REG_DUTY_MAX:     cfg_prdata = 32'(duty_max_r);
      dgpcd_pkg::REG_ENTER_MARGIN: cfg_prdata = 32'(unsigned'(enter_margin_r));
      dgpcd_pkg::REG_EXIT_MARGIN:  cfg_prdata = 32'(unsigned'(exit_margin_r));
      default:                     cfg_prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic s1_vld_r, out_vld_r, out_free, s1_adv, in_xfer;
  logic signed [TW-1:0] surf_r, dew_r;

  assign out_free  = !out_vld_r || out_tready;
  assign s1_adv    = s1_vld_r && out_free;
  assign in_tready = !s1_vld_r || out_free;
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      surf_r <= $signed(in_tdata[TW-1:0]);
      dew_r  <= $signed(in_tdata[2*TW-1:TW]);
    end
  end

  // ---------------- dew hysteresis ----------------
  logic guard_r, guard_nxt, run_pi, zero_integ;
  logic signed [EW-1:0] dew_dist, err;

  assign dew_dist = EW'(surf_r) - EW'(dew_r);
  assign err      = EW'(surf_r) - EW'(target_temp_r);

  always_comb begin
    guard_nxt  = guard_r;
    run_pi     = 1'b1;
    zero_integ = 1'b0;
    if (!guard_r) begin
      if (dew_dist < EW'(enter_margin_r)) begin
        guard_nxt  = 1'b1;
        zero_integ = 1'b1;
        run_pi     = 1'b0;
      end
    end else if (dew_dist > EW'(exit_margin_r)) begin
      guard_nxt = 1'b0;
    end else begin
      run_pi = 1'b0;
    end
  end

  // ---------------- PI law ----------------
  logic signed [MW-1:0] prod_p, prod_i;
  logic signed [PW-1:0] p_term;
  logic signed [IW-1:0] i_step;
  logic signed [SW-1:0] acc_sum, hi_s;
  logic signed [OW-1:0] o_sum, o_hi, o_lo;
  logic [AW-1:0] integ_r, integ_cl, integ_nxt, hi, lo, o_cl;
  logic [AW:0] rnd;
  logic [DW:0] duty_w;
  logic [DW-1:0] duty_pi, duty_nxt;

  assign prod_p = $signed({1'b0, prop_gain_r}) * err;
  assign prod_i = $signed({1'b0, integ_gain_r}) * err;
  // product of prop_gain has 8 fraction bits, exact left shift up to F
  assign p_term = PW'(prod_p) <<< (F - 8);

  generate
    if (F >= 16) begin : g_istep_up
      assign i_step = IW'(prod_i) <<< (F - 16);
    end else begin : g_istep_dn
      // arithmetic shift is floor division
      assign i_step = IW'(prod_i >>> (16 - F));
    end
  endgenerate

  assign hi      = AW'(duty_max_r) << F;
  assign lo      = AW'(duty_min_r) << F;
  assign hi_s    = SW'({1'b0, hi});
  assign acc_sum = SW'($signed({1'b0, integ_r})) + SW'(i_step);

  always_comb begin
    if (acc_sum > hi_s) begin
      integ_cl = hi;
    end else if (acc_sum < 0) begin
      integ_cl = '0;
    end else begin
      integ_cl = acc_sum[AW-1:0];
    end
  end

  assign o_sum = OW'(p_term) + OW'($signed({1'b0, integ_cl}));
  assign o_hi  = OW'({1'b0, hi});
  assign o_lo  = OW'({1'b0, lo});

  // low limit checked first so it wins when the limits cross
  always_comb begin
    if (o_sum < o_lo || o_hi < o_lo) begin
      o_cl = lo;
    end else if (o_sum > o_hi) begin
      o_cl = hi;
    end else begin
      o_cl = o_sum[AW-1:0];
    end
  end

  assign rnd     = {1'b0, o_cl} + ((AW + 1)'(1) << (F - 1));
  assign duty_w  = rnd[AW:F];
  assign duty_pi = (duty_w > (DW + 1)'(dgpcd_pkg::DUTY_CAP)) ? dgpcd_pkg::DUTY_CAP
                                                             : duty_w[DW-1:0];
  assign duty_nxt = run_pi ? duty_pi : '0;

  always_comb begin
    integ_nxt = integ_r;
    if (zero_integ) begin
      integ_nxt = '0;
    end else if (run_pi) begin
      integ_nxt = integ_cl;
    end
  end

  // ---------------- state and output register ----------------
  logic [DW-1:0] duty_r;
  logic prot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      guard_r   <= 1'b0;
      integ_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        guard_r <= guard_nxt;
        integ_r <= integ_nxt;
      end
      if (out_free) begin
        out_vld_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      duty_r <= duty_nxt;
      prot_r <= guard_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = 16'(duty_r);
  assign out_tuser  = prot_r;

  // ---------------- assertions ----------------
  a_prot_zero_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && prot_r |-> duty_r == '0)
    else $error("protection active with nonzero duty");

  a_enter_clears_integ: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(guard_r) |-> integ_r == '0)
    else $error("integral not cleared on entering protection");

  a_duty_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> duty_r <= dgpcd_pkg::DUTY_CAP)
    else $error("duty above cap");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && in_tready |-> out_free)
    else $error("input stage overwritten while held");

  a_out_follows_s1: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_vld_r)
    else $error("advanced item not in output register");

endmodule
